[rtl/tam_pkg.sv]
`timescale 1ns / 1ps

package tam_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;

  // Acceptance limits and the disabled code, sixteenths of a degree
  localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT     = -12'sd880;
  localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT    = 12'sd2000;
  localparam logic signed [SAMPLE_W-1:0] DISABLED_CODE = -12'sd2032;

  // Register reset values
  localparam logic [15:0]                RST_INTERVAL  = 16'd1000;
  localparam logic signed [SAMPLE_W-1:0] RST_EXP_MIN   = -12'sd880;
  localparam logic signed [SAMPLE_W-1:0] RST_EXP_MAX   = 12'sd2000;
  localparam logic [SAMPLE_W-1:0]        RST_SPIKE_THR = 12'd32;
  localparam logic [TIME_W-1:0]          RST_STUCK_TO  = 32'd300000;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_INTERVAL  = 3'd1,
    REG_EXP_MIN   = 3'd2,
    REG_EXP_MAX   = 3'd3,
    REG_SPIKE_THR = 3'd4,
    REG_STUCK_TO  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          now_ms;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       average_valid;
    logic                       accepted;
    logic                       out_of_range;
    logic                       spike;
    logic                       stuck;
    logic [TIME_W-1:0]          stuck_duration;
  } out_t;

  typedef struct packed {
    logic out_of_range;
    logic spike;
    logic stuck;
  } flags_t;

endpackage

[rtl/tam_win_cell.sv]
`timescale 1ns / 1ps

module tam_win_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic signed [tam_pkg::SAMPLE_W-1:0]  d_i,
  output logic signed [tam_pkg::SAMPLE_W-1:0]  q_o
);
  import tam_pkg::*;

  logic signed [SAMPLE_W-1:0] val_q;

  // window starts zeroed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

[rtl/tam_mean_div.sv]
`timescale 1ns / 1ps

module tam_mean_div #(
  parameter int WINDOW_LEN = 10,
  parameter int SUM_W      = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [SUM_W-1:0]             sum_i,
  output logic signed [tam_pkg::SAMPLE_W-1:0] mean_o
);
  import tam_pkg::*;

  // |sum| * ceil(2^SH / N) >> SH is exact for |sum| < 2^SUM_W
  localparam int SH     = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP  = ((2 ** SH) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RECIP);

  logic [SUM_W-1:0]    mag;
  logic                neg_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] quo;

  assign mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= sum_i[SUM_W-1];
      prod_q <= PROD_W'(mag) * PROD_W'(RCP);
    end
  end

  assign quo    = prod_q[SH +: SAMPLE_W];
  assign mean_o = neg_q ? -$signed(quo) : $signed(quo);

endmodule

[rtl/temperature_average_anomaly_monitor.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   in_data_i  (sample, now_ms)
// out       out  out_valid_o / out_ready_i out_data_o (average, flags, stuck_duration)
// config    in   APB psel/penable/pwrite   paddr, pwdata, prdata (6 regs, 4-byte stride)
//
// One item per cycle sustained while the output is not stalled; each accepted item passes
// through the state update, the reciprocal multiply for the mean and the output register.
// The window is a shift chain of WINDOW_LEN cells; oldest sample sits at the end.
// Reset clears window, running sum, timers and flags; registers take their defaults.
// A stalled output holds; items keep entering until the three stages are full.
module temperature_average_anomaly_monitor #(
  parameter int WINDOW_LEN = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tam_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tam_pkg::out_t  out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import tam_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN + 1);

  // ---------------- configuration registers ----------------
  logic                       enable_q;
  logic [15:0]                interval_q;
  logic signed [SAMPLE_W-1:0] exp_min_q, exp_max_q;
  logic [SAMPLE_W-1:0]        spike_thr_q;
  logic [TIME_W-1:0]          stuck_to_q;
  logic                       cfg_wr;
  reg_idx_e                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      interval_q  <= RST_INTERVAL;
      exp_min_q   <= RST_EXP_MIN;
      exp_max_q   <= RST_EXP_MAX;
      spike_thr_q <= RST_SPIKE_THR;
      stuck_to_q  <= RST_STUCK_TO;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:    enable_q    <= pwdata[0];
        REG_INTERVAL:  interval_q  <= pwdata[15:0];
        REG_EXP_MIN:   exp_min_q   <= $signed(pwdata[SAMPLE_W-1:0]);
        REG_EXP_MAX:   exp_max_q   <= $signed(pwdata[SAMPLE_W-1:0]);
        REG_SPIKE_THR: spike_thr_q <= pwdata[SAMPLE_W-1:0];
        REG_STUCK_TO:  stuck_to_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:    prdata = {31'b0, enable_q};
      REG_INTERVAL:  prdata = {16'b0, interval_q};
      REG_EXP_MIN:   prdata = {20'b0, exp_min_q};
      REG_EXP_MAX:   prdata = {20'b0, exp_max_q};
      REG_SPIKE_THR: prdata = {20'b0, spike_thr_q};
      REG_STUCK_TO:  prdata = stuck_to_q;
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline handshake ----------------
  logic v1_q, v2_q, out_v_q;
  logic rdy1, rdy2, rdy3, in_fire, adv2;

  assign rdy3       = !out_v_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && in_ready_o;
  assign adv2       = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_fire)   v1_q <= 1'b1;
      else if (adv2) v1_q <= 1'b0;
      if (adv2)      v2_q <= 1'b1;
      else if (rdy3) v2_q <= 1'b0;
      if (v2_q && rdy3)     out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  // ---------------- state update (stage 1) ----------------
  logic signed [SAMPLE_W-1:0] s;
  logic [TIME_W-1:0]          now;
  logic [TIME_W-1:0]          last_q, change_q, dur_q;
  logic [TIME_W-1:0]          change_d, dur_d, gap, held;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  flags_t                     flags_q, flags_d;
  logic                       take, upd;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic                       have_prev, same;

  assign s    = in_data_i.sample;
  assign now  = in_data_i.now_ms;
  assign gap  = now - last_q;
  assign held = now - change_q;
  assign take = enable_q && (gap >= {16'b0, interval_q})
                && (s > LOW_LIMIT) && (s < HIGH_LIMIT);
  assign upd  = in_fire && take;

  assign diff      = {s[SAMPLE_W-1], s} - {prev_q[SAMPLE_W-1], prev_q};
  assign mag       = diff[SAMPLE_W] ? $unsigned(-diff) : $unsigned(diff);
  // a previous reading of exactly zero means none yet
  assign have_prev = (prev_q != '0);
  assign same      = have_prev && (mag == '0);

  always_comb begin
    flags_d.out_of_range = (s < exp_min_q) || (s > exp_max_q);
    flags_d.spike        = have_prev && (mag > {1'b0, spike_thr_q});
    flags_d.stuck        = 1'b0;
    change_d             = now;
    dur_d                = '0;
    if (same && (change_q != '0)) begin
      change_d      = change_q;
      dur_d         = held;
      flags_d.stuck = held > stuck_to_q;
    end
  end

  // window chain: cell 0 takes the new sample, last cell holds the oldest
  logic signed [SAMPLE_W-1:0] win [WINDOW_LEN];

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_win
    if (i == 0) begin : g_head
      tam_win_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (upd),
        .d_i     (s),
        .q_o     (win[i])
      );
    end else begin : g_body
      tam_win_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (upd),
        .d_i     (win[i-1]),
        .q_o     (win[i])
      );
    end
  end

  assign sum_d = sum_q - SUM_W'(win[WINDOW_LEN-1]) + SUM_W'(s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      change_q <= '0;
      dur_q    <= '0;
      prev_q   <= '0;
      sum_q    <= '0;
      flags_q  <= '0;
    end else if (upd) begin
      last_q   <= now;
      change_q <= change_d;
      dur_q    <= dur_d;
      prev_q   <= s;
      sum_q    <= sum_d;
      flags_q  <= flags_d;
    end
  end

  // stage 1 item: snapshot of the state as the item leaves it
  logic signed [SUM_W-1:0] sum1_q;
  logic                    en1_q, acc1_q;
  flags_t                  flags1_q;
  logic [TIME_W-1:0]       dur1_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum1_q   <= take ? sum_d : sum_q;
      en1_q    <= enable_q;
      acc1_q   <= take;
      flags1_q <= take ? flags_d : flags_q;
      dur1_q   <= take ? dur_d : dur_q;
    end
  end

  // ---------------- mean (stage 2) ----------------
  logic signed [SAMPLE_W-1:0] mean;
  logic                       en2_q, acc2_q;
  flags_t                     flags2_q;
  logic [TIME_W-1:0]          dur2_q;

  tam_mean_div #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (adv2),
    .sum_i  (sum1_q),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      en2_q    <= en1_q;
      acc2_q   <= acc1_q;
      flags2_q <= flags1_q;
      dur2_q   <= dur1_q;
    end
  end

  // ---------------- output register ----------------
  out_t out_d, out_q;

  always_comb begin
    out_d.average        = en2_q ? mean : DISABLED_CODE;
    out_d.average_valid  = en2_q && (mean > LOW_LIMIT) && (mean < HIGH_LIMIT);
    out_d.accepted       = acc2_q;
    out_d.out_of_range   = flags2_q.out_of_range;
    out_d.spike          = flags2_q.spike;
    out_d.stuck          = flags2_q.stuck;
    out_d.stuck_duration = dur2_q;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  // an accepted sample lies within the limits, so its mean must be valid
  a_acc_mean_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.average_valid)
    else $error("accepted item with invalid mean");

  // stuck needs a duration above the timeout, hence nonzero
  a_stuck_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stuck |-> out_data_o.stuck_duration != '0)
    else $error("stuck flagged with zero duration");

  // an accepted sample restarts the interval at its own timestamp
  a_last_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> last_q == $past(now))
    else $error("last accept time not updated");

  // a stalled stage 1 item is not dropped
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q)
    else $error("stage 1 item lost under stall");

endmodule
